>>> rtl/osat_pkg.sv
package osat_pkg;

    typedef enum logic [2:0] {
        OP_TICK        = 3'd0,
        OP_INIT        = 3'd1,
        OP_SET_TIMEOUT = 3'd2,
        OP_SET_ABS     = 3'd3,
        OP_CLEAR       = 3'd4,
        OP_READ        = 3'd5,
        OP_START       = 3'd6,
        OP_STOP        = 3'd7
    } op_t;

    localparam int unsigned MIN_TIMEOUT = 5;
    localparam int unsigned NUM_PRESCALE_REGS = 4;
    localparam int unsigned CFG_INDEX_BITS = 8;
    localparam int unsigned PHASE_BITS = 10;

    typedef struct packed {
        logic        en;
        logic        hit;
        op_t         op;
        logic [15:0] value;
    } chan_req_t;

    function automatic logic [PHASE_BITS:0] divisor(input logic [1:0] sel);
        logic [PHASE_BITS:0] d;
        case (sel)
            2'd0:    d = 11'd1;
            2'd1:    d = 11'd64;
            2'd2:    d = 11'd256;
            default: d = 11'd1024;
        endcase
        return d;
    endfunction

endpackage

>>> rtl/osat_chan.sv
module osat_chan #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  osat_pkg::chan_req_t     req,
    input  logic [1:0]              prescale,
    output logic [COUNTER_BITS-1:0] read_now,
    output logic                    fire
);

    localparam int PB = osat_pkg::PHASE_BITS;

    logic [COUNTER_BITS-1:0] count_reg, count_next;
    logic [COUNTER_BITS-1:0] reload_reg, reload_next;
    logic [COUNTER_BITS-1:0] mark_reg, mark_next;
    logic [COUNTER_BITS-1:0] base_reg, base_next;
    logic                    armed_reg, armed_next;
    logic                    irq_reg, irq_next;
    logic                    run_reg, run_next;
    logic [PB-1:0]           phase_reg, phase_next;

    logic [PB:0]             phase_inc;
    logic [COUNTER_BITS-1:0] tgt;
    logic [COUNTER_BITS-1:0] diff;
    logic [COUNTER_BITS-1:0] min_pre;
    logic [COUNTER_BITS-1:0] pre_rel;
    logic [COUNTER_BITS-1:0] pre_abs;

    always_comb begin
        if (armed_reg) begin
            if (count_reg >= mark_reg) begin
                read_now = base_reg + count_reg - mark_reg;
            end else begin
                read_now = base_reg;
            end
        end else begin
            read_now = base_reg + count_reg;
        end
    end

    assign phase_inc = {1'b0, phase_reg} + (PB+1)'(1);
    assign tgt       = COUNTER_BITS'(req.value);
    assign diff      = tgt - read_now;
    assign min_pre   = {COUNTER_BITS{1'b0}} - COUNTER_BITS'(osat_pkg::MIN_TIMEOUT);
    assign pre_rel   = (req.value < 16'(osat_pkg::MIN_TIMEOUT)) ? min_pre
                     : ({COUNTER_BITS{1'b0}} - tgt);
    assign pre_abs   = ((diff != '0) && (diff < COUNTER_BITS'(osat_pkg::MIN_TIMEOUT)))
                     ? min_pre : (read_now - tgt);

    always_comb begin
        count_next  = count_reg;
        reload_next = reload_reg;
        mark_next   = mark_reg;
        base_next   = base_reg;
        armed_next  = armed_reg;
        irq_next    = irq_reg;
        run_next    = run_reg;
        phase_next  = phase_reg;
        fire        = 1'b0;
        if (req.en) begin
            if (req.op == osat_pkg::OP_TICK) begin
                if (run_reg) begin
                    if (phase_inc < osat_pkg::divisor(prescale)) begin
                        phase_next = phase_inc[PB-1:0];
                    end else begin
                        phase_next = '0;
                        if (count_reg != {COUNTER_BITS{1'b1}}) begin
                            count_next = count_reg + COUNTER_BITS'(1);
                        end else if (armed_reg && irq_reg) begin
                            fire        = 1'b1;
                            armed_next  = 1'b0;
                            irq_next    = 1'b0;
                            base_next   = base_reg - mark_reg;
                            mark_next   = '0;
                            reload_next = '0;
                            count_next  = '0;
                        end else begin
                            count_next = reload_reg;
                        end
                    end
                end
            end else if (req.hit) begin
                unique case (req.op) inside
                    osat_pkg::OP_INIT: begin
                        reload_next = '0;
                        base_next   = '0;
                        mark_next   = '0;
                        armed_next  = 1'b1;
                        irq_next    = 1'b1;
                        count_next  = '0;
                        phase_next  = '0;
                        run_next    = 1'b1;
                    end
                    osat_pkg::OP_SET_TIMEOUT: begin
                        base_next   = read_now;
                        reload_next = pre_rel;
                        mark_next   = pre_rel;
                        armed_next  = 1'b1;
                        irq_next    = 1'b1;
                        count_next  = pre_rel;
                        phase_next  = '0;
                        run_next    = 1'b1;
                    end
                    osat_pkg::OP_SET_ABS: begin
                        base_next   = read_now;
                        reload_next = pre_abs;
                        mark_next   = pre_abs;
                        armed_next  = 1'b1;
                        irq_next    = 1'b1;
                        count_next  = pre_abs;
                        phase_next  = '0;
                        run_next    = 1'b1;
                    end
                    osat_pkg::OP_CLEAR: begin
                        armed_next = 1'b0;
                        irq_next   = 1'b0;
                    end
                    osat_pkg::OP_START: begin
                        if (!run_reg) begin
                            count_next = reload_reg;
                            phase_next = '0;
                        end
                        run_next = 1'b1;
                    end
                    osat_pkg::OP_STOP: begin
                        run_next = 1'b0;
                    end
                    osat_pkg::OP_READ, osat_pkg::OP_TICK: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            reload_reg <= '0;
            mark_reg   <= '0;
            base_reg   <= '0;
            armed_reg  <= 1'b0;
            irq_reg    <= 1'b0;
            run_reg    <= 1'b0;
            phase_reg  <= '0;
        end else begin
            count_reg  <= count_next;
            reload_reg <= reload_next;
            mark_reg   <= mark_next;
            base_reg   <= base_next;
            armed_reg  <= armed_next;
            irq_reg    <= irq_next;
            run_reg    <= run_next;
            phase_reg  <= phase_next;
        end
    end

endmodule

>>> rtl/one_shot_alarm_overflow_timer.sv
// A bank of prescaled up-counting timers that emulate one-shot alarms on overflow.
// Requests arrive on the s_ channel (valid/ready): an operation code, a timer index
// and a 16-bit value. Every request produces exactly one result on the m_ channel:
// the corrected elapsed count for a read, the mask of alarms fired for a tick,
// and zeros otherwise.
// A request is captured in an input register and processed once the result register
// is free (empty, or m_ready high), when all channel state updates and the result
// register loads. One request is taken per cycle unless a waiting result stalls it.
// The result register decouples the two sides: a new request is still accepted
// while a result waits, and only when both the input and result registers are
// full and m_ready is low does s_ready drop.
// The prescale selects are written through the cfg_ port, which is always ready;
// writes are meant to happen while no request is in flight.
// A synchronous active-low reset clears all counters, bases, flags, prescale
// selects and both pipeline valid bits.
module one_shot_alarm_overflow_timer #(
    parameter int NUM_TIMERS   = 4,
    parameter int COUNTER_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [2:0]                          s_operation,
    input  logic [1:0]                          s_timer_index,
    input  logic [15:0]                         s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [15:0]                         m_read_value,
    output logic [3:0]                          m_alarm_mask,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [osat_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [1:0]                          cfg_data
);

    logic                in_valid_reg;
    osat_pkg::op_t       op_reg;
    logic [1:0]          idx_reg;
    logic [15:0]         value_reg;
    logic                out_valid_reg;
    logic [15:0]         read_value_reg;
    logic [3:0]          alarm_mask_reg;
    logic [1:0]          prescale_reg [NUM_TIMERS];

    logic                    advance;
    logic [NUM_TIMERS-1:0]   fire_vec;
    logic [COUNTER_BITS-1:0] chan_read [NUM_TIMERS];
    logic [COUNTER_BITS-1:0] read_sel;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= osat_pkg::op_t'(s_operation);
            idx_reg   <= s_timer_index;
            value_reg <= s_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                prescale_reg[i] <= 2'd0;
            end
        end else if (cfg_valid && cfg_ready) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                if (i < osat_pkg::NUM_PRESCALE_REGS &&
                    cfg_index == osat_pkg::CFG_INDEX_BITS'(i)) begin
                    prescale_reg[i] <= cfg_data;
                end
            end
        end
    end

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_chan
        osat_pkg::chan_req_t req;

        assign req.en    = advance;
        assign req.hit   = (32'(idx_reg) == g);
        assign req.op    = op_reg;
        assign req.value = value_reg;

        osat_chan #(
            .COUNTER_BITS(COUNTER_BITS)
        ) u_chan (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .req      (req),
            .prescale (prescale_reg[g]),
            .read_now (chan_read[g]),
            .fire     (fire_vec[g])
        );
    end

    always_comb begin
        read_sel = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (32'(idx_reg) == i) begin
                read_sel = chan_read[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            read_value_reg <= (op_reg == osat_pkg::OP_READ) ? 16'(read_sel) : 16'd0;
            alarm_mask_reg <= (op_reg == osat_pkg::OP_TICK) ? 4'(fire_vec) : 4'd0;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_read_value = read_value_reg;
    assign m_alarm_mask = alarm_mask_reg;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int TIMERS = 4;
    localparam int LIVE = 0;
    localparam int PLAN = 1;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct {
        osat_pkg::op_t op;
        logic [1:0]    idx;
        logic [15:0]   val;
        int unsigned   gap;
    } timer_req_t;

    typedef struct packed {
        logic [15:0] read_value;
        logic [3:0]  alarm_mask;
    } timer_resp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_operation = 3'd0;
    logic [1:0] s_timer_index = 2'd0;
    logic [15:0] s_value = 16'd0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [15:0] m_read_value;
    logic [3:0] m_alarm_mask;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [osat_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [1:0] cfg_data = 2'd0;

    // Two copies of the timer bank: one follows accepted requests, the other
    // is advanced while stimulus is generated so that targets can be aimed.
    logic [1:0] tmr_presc [2][TIMERS];
    logic [15:0] tmr_count [2][TIMERS];
    logic [15:0] tmr_reload [2][TIMERS];
    logic [15:0] tmr_mark [2][TIMERS];
    logic [15:0] tmr_base [2][TIMERS];
    logic tmr_armed [2][TIMERS];
    logic tmr_irq [2][TIMERS];
    logic tmr_run [2][TIMERS];
    int unsigned tmr_phase [2][TIMERS];

    timer_req_t req_q[$];
    timer_resp_t due_responses[$];

    int unsigned gap_cnt = 0;
    int unsigned stall_cnt = 0;
    int unsigned stall_len = 0;
    int unsigned rx_run_left = 0;
    logic rx_calm = 1'b0;
    int unsigned tx_run_left = 0;
    logic tx_calm = 1'b0;
    int unsigned plan_cnt = 0;
    int unsigned fail_cnt = 0;
    int unsigned resp_seen = 0;
    int unsigned idle_cycles = 0;

    one_shot_alarm_overflow_timer DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_operation(s_operation),
        .s_timer_index(s_timer_index),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_read_value(m_read_value),
        .m_alarm_mask(m_alarm_mask),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [15:0] elapsed_of(input int v, input logic [1:0] t);
        logic [15:0] acc;
        acc = tmr_base[v][t];
        if (!tmr_armed[v][t]) begin
            acc = acc + tmr_count[v][t];
        end else if (tmr_count[v][t] >= tmr_mark[v][t]) begin
            acc = acc + (tmr_count[v][t] - tmr_mark[v][t]);
        end
        return acc;
    endfunction

    function automatic void resume(input int v, input logic [1:0] t);
        if (!tmr_run[v][t]) begin
            tmr_count[v][t] = tmr_reload[v][t];
            tmr_phase[v][t] = 0;
        end
        tmr_run[v][t] = 1'b1;
    endfunction

    function automatic void arm_timeout(input int v, input logic [1:0] t,
            input logic [16:0] span);
        logic [16:0] pre;
        if (span < osat_pkg::MIN_TIMEOUT) begin
            span = 17'(osat_pkg::MIN_TIMEOUT);
        end
        tmr_run[v][t] = 1'b0;
        tmr_base[v][t] = elapsed_of(v, t);
        pre = 17'h10000 - span;
        tmr_reload[v][t] = pre[15:0];
        tmr_mark[v][t] = pre[15:0];
        tmr_irq[v][t] = 1'b1;
        tmr_armed[v][t] = 1'b1;
        resume(v, t);
    endfunction

    function automatic logic [3:0] advance_bank(input int v);
        logic [3:0] fired;
        int unsigned ratio;
        fired = '0;
        for (int t = 0; t < TIMERS; t++) begin
            case (tmr_presc[v][t])
                2'd0: ratio = 1;
                2'd1: ratio = 64;
                2'd2: ratio = 256;
                default: ratio = 1024;
            endcase
            if (tmr_run[v][t]) begin
                tmr_phase[v][t] = tmr_phase[v][t] + 1;
                if (tmr_phase[v][t] >= ratio) begin
                    tmr_phase[v][t] = 0;
                    if (tmr_count[v][t] != 16'hFFFF) begin
                        tmr_count[v][t] = tmr_count[v][t] + 16'd1;
                    end else begin
                        tmr_count[v][t] = tmr_reload[v][t];
                        if (tmr_armed[v][t] && tmr_irq[v][t]) begin
                            fired[t] = 1'b1;
                            tmr_armed[v][t] = 1'b0;
                            tmr_irq[v][t] = 1'b0;
                            tmr_base[v][t] = tmr_base[v][t] - tmr_mark[v][t];
                            tmr_mark[v][t] = '0;
                            tmr_reload[v][t] = '0;
                            tmr_run[v][t] = 1'b0;
                            resume(v, 2'(t));
                        end
                    end
                end
            end
        end
        return fired;
    endfunction

    function automatic timer_resp_t timer_bank_step(input int v, input osat_pkg::op_t op,
            input logic [1:0] t, input logic [15:0] val);
        timer_resp_t r;
        logic [15:0] cur;
        logic [16:0] span;
        r = '0;
        case (op)
            osat_pkg::OP_TICK: begin
                r.alarm_mask = advance_bank(v);
            end
            osat_pkg::OP_INIT: begin
                tmr_run[v][t] = 1'b0;
                tmr_reload[v][t] = '0;
                tmr_base[v][t] = '0;
                tmr_mark[v][t] = '0;
                tmr_armed[v][t] = 1'b1;
                tmr_irq[v][t] = 1'b1;
                resume(v, t);
            end
            osat_pkg::OP_SET_TIMEOUT: begin
                arm_timeout(v, t, {1'b0, val});
            end
            osat_pkg::OP_SET_ABS: begin
                cur = elapsed_of(v, t);
                if (cur < val) begin
                    span = {1'b0, val} - {1'b0, cur};
                end else if (cur > val) begin
                    span = 17'h10000 + {1'b0, val} - {1'b0, cur};
                end else begin
                    span = 17'h10000;
                end
                arm_timeout(v, t, span);
            end
            osat_pkg::OP_CLEAR: begin
                tmr_armed[v][t] = 1'b0;
                tmr_irq[v][t] = 1'b0;
            end
            osat_pkg::OP_READ: begin
                r.read_value = elapsed_of(v, t);
            end
            osat_pkg::OP_START: begin
                resume(v, t);
            end
            default: begin
                tmr_run[v][t] = 1'b0;
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin : drive_proc
        timer_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_cnt <= 0;
        end else begin
            if (cfg_valid && cfg_ready && cfg_index < osat_pkg::NUM_PRESCALE_REGS) begin
                tmr_presc[LIVE][cfg_index] = cfg_data;
            end
            if (s_valid && s_ready) begin
                due_responses.push_back(timer_bank_step(LIVE,
                                                        osat_pkg::op_t'(s_operation),
                                                        s_timer_index, s_value));
            end
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (req_q.size() != 0 && gap_cnt >= req_q[0].gap) begin
                nxt = req_q.pop_front();
                s_valid <= 1'b1;
                s_operation <= nxt.op;
                s_timer_index <= nxt.idx;
                s_value <= nxt.val;
                gap_cnt <= 0;
            end else begin
                s_valid <= 1'b0;
                if (req_q.size() != 0) begin
                    gap_cnt <= gap_cnt + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_proc
        timer_resp_t want;
        int unsigned next_stall;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_cnt <= 0;
            stall_len <= 0;
        end else if (m_valid && m_ready) begin
            if (due_responses.size() == 0) begin
                if (fail_cnt < 10) begin
                    $display("unexpected response %0d: read_value %h alarm_mask %b",
                             resp_seen, m_read_value, m_alarm_mask);
                end
                fail_cnt++;
            end else begin
                want = due_responses.pop_front();
                if (want.read_value !== m_read_value || want.alarm_mask !== m_alarm_mask) begin
                    if (fail_cnt < 10) begin
                        $display("mismatch on response %0d: read_value exp %h got %h, %s %b got %b",
                                 resp_seen, want.read_value, m_read_value,
                                 "alarm_mask exp", want.alarm_mask, m_alarm_mask);
                    end
                    fail_cnt++;
                end
            end
            resp_seen++;
            if (rx_run_left == 0) begin
                rx_run_left <= $urandom_range(10, 120);
                rx_calm <= ($urandom_range(0, 3) == 0);
            end else begin
                rx_run_left <= rx_run_left - 1;
            end
            next_stall = rx_calm ? 0 : $urandom_range(0, 16);
            stall_len <= next_stall;
            stall_cnt <= 0;
            m_ready <= (next_stall == 0);
        end else if (stall_cnt < stall_len) begin
            stall_cnt <= stall_cnt + 1;
            m_ready <= (stall_cnt + 1 >= stall_len);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_request(input osat_pkg::op_t op, input logic [1:0] idx,
            input logic [15:0] val);
        timer_req_t r;
        if (tx_run_left == 0) begin
            tx_run_left = $urandom_range(10, 120);
            tx_calm = ($urandom_range(0, 3) == 0);
        end else begin
            tx_run_left--;
        end
        r.op = op;
        r.idx = idx;
        r.val = val;
        r.gap = tx_calm ? 0 : $urandom_range(0, 16);
        void'(timer_bank_step(PLAN, op, idx, val));
        req_q.push_back(r);
        plan_cnt++;
    endtask

    task automatic write_prescale(input logic [osat_pkg::CFG_INDEX_BITS-1:0] idx,
            input logic [1:0] sel);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= sel;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < osat_pkg::NUM_PRESCALE_REGS) begin
            tmr_presc[PLAN][idx] = sel;
        end
    endtask

    task automatic set_prescalers(input logic [1:0] p0, input logic [1:0] p1,
            input logic [1:0] p2, input logic [1:0] p3);
        write_prescale(osat_pkg::CFG_INDEX_BITS'(0), p0);
        write_prescale(osat_pkg::CFG_INDEX_BITS'(1), p1);
        write_prescale(osat_pkg::CFG_INDEX_BITS'(2), p2);
        write_prescale(osat_pkg::CFG_INDEX_BITS'(3), p3);
    endtask

    task automatic drain();
        do @(negedge aclk); while (req_q.size() != 0 || s_valid || due_responses.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [15:0] quick_timeout(input logic [1:0] t);
        if (tmr_presc[PLAN][t] == 2'd0) begin
            return 16'($urandom_range(0, 40));
        end
        return 16'($urandom_range(0, 6));
    endfunction

    task automatic gen_mix(input int unsigned n);
        int unsigned stop_at;
        int unsigned len;
        logic [1:0] t;
        stop_at = plan_cnt + n;
        while (plan_cnt < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    t = 2'($urandom_range(0, 3));
                    case ($urandom_range(0, 4))
                        0: queue_request(osat_pkg::OP_SET_TIMEOUT, t, quick_timeout(t));
                        1: queue_request(osat_pkg::OP_SET_ABS, t,
                                         elapsed_of(PLAN, t) + quick_timeout(t));
                        2: queue_request(osat_pkg::OP_INIT, t, 16'($urandom));
                        3: begin
                            queue_request(osat_pkg::OP_SET_TIMEOUT, t, quick_timeout(t));
                            queue_request(osat_pkg::OP_CLEAR, t, 16'($urandom));
                        end
                        default: queue_request(osat_pkg::OP_SET_TIMEOUT, t, 16'($urandom));
                    endcase
                    len = (tmr_presc[PLAN][t] == 2'd0) ? $urandom_range(1, 50)
                                                         : $urandom_range(1, 450);
                    repeat (len) begin
                        case ($urandom_range(0, 19))
                            0: queue_request(osat_pkg::OP_READ, 2'($urandom),
                                             16'($urandom));
                            1: queue_request(osat_pkg::op_t'($urandom_range(4, 7)),
                                             2'($urandom), 16'($urandom));
                            default: queue_request(osat_pkg::OP_TICK, 2'($urandom),
                                                   16'($urandom));
                        endcase
                    end
                    queue_request(osat_pkg::OP_READ, t, 16'($urandom));
                end
                6, 7: begin
                    repeat ($urandom_range(1, 8)) begin
                        queue_request(osat_pkg::op_t'($urandom_range(0, 7)), 2'($urandom),
                                      16'($urandom));
                    end
                end
                default: begin
                    repeat ($urandom_range(1, 30)) begin
                        queue_request(osat_pkg::OP_TICK, 2'($urandom), 16'($urandom));
                    end
                end
            endcase
        end
    endtask

    initial begin : stim_proc
        for (int v = 0; v < 2; v++) begin
            for (int t = 0; t < TIMERS; t++) begin
                tmr_presc[v][t] = '0;
                tmr_count[v][t] = '0;
                tmr_reload[v][t] = '0;
                tmr_mark[v][t] = '0;
                tmr_base[v][t] = '0;
                tmr_armed[v][t] = 1'b0;
                tmr_irq[v][t] = 1'b0;
                tmr_run[v][t] = 1'b0;
                tmr_phase[v][t] = 0;
            end
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        set_prescalers(2'd0, 2'd0, 2'd0, 2'd0);
        queue_request(osat_pkg::OP_READ, 2'd0, 16'h0000);
        queue_request(osat_pkg::OP_TICK, 2'd3, 16'hFFFF);
        queue_request(osat_pkg::OP_INIT, 2'd0, 16'h0000);
        // A target equal to the current count arms a full period.
        queue_request(osat_pkg::OP_SET_ABS, 2'd0, 16'h0000);
        queue_request(osat_pkg::OP_READ, 2'd0, 16'hFFFF);
        queue_request(osat_pkg::OP_INIT, 2'd1, 16'h5555);
        queue_request(osat_pkg::OP_SET_ABS, 2'd1, 16'h0003);
        queue_request(osat_pkg::OP_SET_TIMEOUT, 2'd2, 16'h0000);
        queue_request(osat_pkg::OP_SET_TIMEOUT, 2'd3, 16'hFFFF);
        repeat (6) queue_request(osat_pkg::OP_TICK, 2'($urandom), 16'($urandom));
        queue_request(osat_pkg::OP_READ, 2'd1, 16'hAAAA);
        queue_request(osat_pkg::OP_READ, 2'd2, 16'h0000);
        queue_request(osat_pkg::OP_CLEAR, 2'd3, 16'h0000);
        queue_request(osat_pkg::OP_STOP, 2'd3, 16'hFFFF);
        queue_request(osat_pkg::OP_START, 2'd3, 16'h0000);
        queue_request(osat_pkg::OP_START, 2'd3, 16'hFFFF);
        queue_request(osat_pkg::OP_STOP, 2'd0, 16'h0000);
        queue_request(osat_pkg::OP_TICK, 2'd2, 16'h1234);
        queue_request(osat_pkg::OP_READ, 2'd0, 16'h0000);
        queue_request(osat_pkg::OP_READ, 2'd3, 16'hFFFF);
        gen_mix(450);
        drain();

        set_prescalers(2'd1, 2'd0, 2'd1, 2'd0);
        gen_mix(150);
        drain();

        set_prescalers(2'd1, 2'd3, 2'd1, 2'd3);
        queue_request(osat_pkg::OP_SET_TIMEOUT, 2'd2, 16'h0005);
        queue_request(osat_pkg::OP_SET_ABS, 2'd0, elapsed_of(PLAN, 2'd0) + 16'd5);
        repeat (325) queue_request(osat_pkg::OP_TICK, 2'($urandom), 16'($urandom));
        queue_request(osat_pkg::OP_READ, 2'd2, 16'($urandom));
        queue_request(osat_pkg::OP_READ, 2'd0, 16'($urandom));
        gen_mix(40);
        drain();

        set_prescalers(2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
        write_prescale(osat_pkg::CFG_INDEX_BITS'(osat_pkg::NUM_PRESCALE_REGS), 2'd3);
        write_prescale({osat_pkg::CFG_INDEX_BITS{1'b1}}, 2'd2);
        gen_mix(150);
        drain();

        set_prescalers(2'd0, 2'd1, 2'd0, 2'd2);
        gen_mix(150);
        drain();

        repeat (8) @(posedge aclk);
        if (fail_cnt == 0 && due_responses.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/osat_pkg.sv
rtl/osat_chan.sv
rtl/one_shot_alarm_overflow_timer.sv
bench/tb_top.sv
